// ===== rtl/per_core_priority_ready_queues_macros.svh =====
// Assertion macros for the ready-queue scheduler.
// Used by the top level only; empty under synthesis.
`ifndef PER_CORE_PRIORITY_READY_QUEUES_MACROS_SVH
`define PER_CORE_PRIORITY_READY_QUEUES_MACROS_SVH
`ifndef SYNTHESIS
`define PCRQ_ASSERT_IMP(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define PCRQ_ASSERT_NXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PCRQ_ASSERT_IMP(label, clk, rstn, a, c)
`define PCRQ_ASSERT_NXT(label, clk, rstn, a, c)
`endif
`endif

// ===== rtl/pcrq_pkg.sv =====
// Shared opcodes and configuration register indices for the ready-queue scheduler.
// No dependencies.
package pcrq_pkg;
  typedef enum logic [1:0] {
    OP_ENQ      = 2'd0,
    OP_DEQ      = 2'd1,
    OP_DEQ_FREE = 2'd2,
    OP_NOP      = 2'd3
  } op_t;
  localparam int CFG_TS_LOW  = 0;
  localparam int CFG_TS_HIGH = 1;
endpackage

// ===== rtl/pcrq_slot_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the slot link and attribute stores; no dependencies.
module pcrq_slot_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/per_core_priority_ready_queues.sv =====
// Per-core priority ready queues. Each core has one doubly linked FIFO of
// thread slots per priority level, kept in single-port-write slot stores
// (one RAM each for next links, previous links and attributes). A state
// machine sequences the store accesses. An enqueue reads the queue's
// head and tail, writes the new slot, then links its neighbour. A
// highest-priority dequeue takes the head of the top non-empty level; a
// no-affinity dequeue walks each non-empty level from its head and takes
// the first slot with no core affinity. The level scan steps one level per
// cycle from the top. Between requests in_ready is high. One result request
// follows each input request and is held in an output register until taken.
// in_ready returns in the cycle after the result is taken.
// Stores need no clearing pass.
`include "per_core_priority_ready_queues_macros.svh"
module per_core_priority_ready_queues
  import pcrq_pkg::*;
#(
  parameter int NUM_CORES       = 4,
  parameter int PRIORITY_LEVELS = 16,
  parameter int THREAD_SLOTS    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [3:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [1:0] in_core,
  input  logic [5:0] in_thread_id,
  input  logic [3:0] in_priority_req,
  input  logic [3:0] in_fixed_priority,
  input  logic [2:0] in_affinity,
  input  logic       in_at_head,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_found,
  output logic [5:0] out_out_thread,
  output logic [3:0] out_out_priority,
  output logic [3:0] out_out_fixed_priority,
  output logic [2:0] out_out_affinity,
  output logic [6:0] out_ready_count
);
  localparam int SW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int LW = $clog2(PRIORITY_LEVELS);
  localparam int CW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int QN = NUM_CORES * PRIORITY_LEVELS;
  localparam int QW = $clog2(QN);
  localparam int NW = $clog2(THREAD_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_ENQ_RD, S_ENQ_WR, S_ENQ_LINK, S_SCAN, S_HEAD_RD, S_SLOT_RD,
    S_SLOT_CHK, S_UNL_WR, S_UNL_WR2, S_DONE, S_OUT
  } state_t;

  state_t state_r;
  logic [3:0] ts_low_r, ts_high_r;
  logic [PRIORITY_LEVELS-1:0] nonempty_r [NUM_CORES];
  logic [NW-1:0] count_r [NUM_CORES];
  logic [THREAD_SLOTS-1:0] queued_r;

  // Per-queue head/tail: small memories indexed by q
  logic [SW-1:0] head_mem [QN];
  logic [SW-1:0] tail_mem [QN];

  logic [1:0]    op_r;
  logic [CW-1:0] core_r;
  logic [SW-1:0] tid_r;
  logic [LW-1:0] lvl_r;
  logic [3:0]    fixp_r;
  logic [2:0]    aff_r;
  logic          ath_r, bad_r;
  logic [SW-1:0] cur_r, head_r, tail_r, nxt_r, prv_r;
  logic [3:0]    sp_r, sfp_r;
  logic [2:0]    saff_r;
  logic          found_r;
  logic [6:0]    cnt_out_r;

  // slot store ports
  logic [SW-1:0] ram_waddr, ram_raddr;
  logic [SW-1:0] nl_wd, pl_wd;
  logic          nl_we, pl_we, at_we;
  logic [SW-1:0] nl_wa, pl_wa;
  logic [SW-1:0] nl_rd, pl_rd;
  logic [10:0]   at_wd, at_rd;

  pcrq_slot_ram #(.DEPTH(THREAD_SLOTS), .WIDTH(SW)) u_next (
    .clk, .we(nl_we), .waddr(nl_wa), .wdata(nl_wd), .raddr(ram_raddr), .rdata(nl_rd));
  pcrq_slot_ram #(.DEPTH(THREAD_SLOTS), .WIDTH(SW)) u_prev (
    .clk, .we(pl_we), .waddr(pl_wa), .wdata(pl_wd), .raddr(ram_raddr), .rdata(pl_rd));
  pcrq_slot_ram #(.DEPTH(THREAD_SLOTS), .WIDTH(11)) u_attr (
    .clk, .we(at_we), .waddr(ram_waddr), .wdata(at_wd), .raddr(ram_raddr), .rdata(at_rd));

  logic [QW-1:0] q_idx;
  assign q_idx = QW'(core_r * PRIORITY_LEVELS + lvl_r);

  logic in_fire, out_fire;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  logic cur_free, is_head, is_tail, in_band, lvl_set;
  logic [4:0] np;
  assign cur_free = (32'(at_rd[2:0]) >= NUM_CORES);
  assign is_head  = (cur_r == head_r);
  assign is_tail  = (cur_r == tail_r);
  assign in_band  = (sfp_r >= ts_low_r) && (sfp_r <= ts_high_r);
  assign np       = {1'b0, sp_r} - 5'd1;
  assign lvl_set  = nonempty_r[core_r][lvl_r];

  // store write controls, decoded from state
  always_comb begin
    nl_we = 1'b0; pl_we = 1'b0; at_we = 1'b0;
    nl_wa = tid_r; pl_wa = tid_r; nl_wd = tid_r; pl_wd = tid_r;
    ram_waddr = tid_r; at_wd = {fixp_r, 4'(lvl_r), aff_r};
    ram_raddr = cur_r;
    unique case (state_r)
      S_ENQ_WR: begin
        at_we = 1'b1; nl_we = 1'b1; pl_we = 1'b1;
        if (!lvl_set) begin
          nl_wd = tid_r; pl_wd = tid_r;
        end else if (ath_r) begin
          nl_wd = head_r; pl_wd = tid_r;
        end else begin
          nl_wd = tid_r; pl_wd = tail_r;
        end
      end
      S_ENQ_LINK: begin
        if (lvl_set && ath_r) begin
          pl_we = 1'b1; pl_wa = head_r; pl_wd = tid_r;
        end else if (lvl_set) begin
          nl_we = 1'b1; nl_wa = tail_r; nl_wd = tid_r;
        end
      end
      S_UNL_WR: begin
        if (!(is_head && is_tail) && !is_head) begin
          nl_we = 1'b1; nl_wa = prv_r; nl_wd = nxt_r;
        end
        if (!(is_head && is_tail) && !is_tail) begin
          pl_we = 1'b1; pl_wa = nxt_r; pl_wd = prv_r;
        end
      end
      S_UNL_WR2: begin
        if (op_r == OP_DEQ && in_band) begin
          at_we = 1'b1; ram_waddr = cur_r;
          at_wd = {sfp_r, ((np[4] || np[3:0] < ts_low_r) ? sfp_r : np[3:0]), saff_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ts_low_r  <= 4'd1;
      ts_high_r <= 4'd14;
      queued_r  <= '0;
      for (int i = 0; i < NUM_CORES; i++) begin
        nonempty_r[i] <= '0;
        count_r[i]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'(CFG_TS_LOW)) ts_low_r <= cfg_data;
        else ts_high_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          op_r   <= in_opcode;
          core_r <= CW'(in_core);
          tid_r  <= SW'(in_thread_id);
          // dequeues scan from the top level
          if (in_opcode == OP_ENQ)
            lvl_r <= (32'(in_priority_req) >= PRIORITY_LEVELS) ?
                     LW'(PRIORITY_LEVELS - 1) : LW'(in_priority_req);
          else lvl_r <= LW'(PRIORITY_LEVELS - 1);
          fixp_r <= in_fixed_priority;
          aff_r  <= in_affinity;
          ath_r  <= in_at_head;
          found_r <= 1'b0;
          bad_r  <= (32'(in_core) >= NUM_CORES);
          if (32'(in_core) < NUM_CORES && in_opcode == OP_ENQ &&
              32'(in_thread_id) < THREAD_SLOTS && !queued_r[SW'(in_thread_id)])
            state_r <= S_ENQ_RD;
          else if (32'(in_core) < NUM_CORES &&
                   (in_opcode == OP_DEQ || in_opcode == OP_DEQ_FREE))
            state_r <= S_SCAN;
          else state_r <= S_DONE;
        end
        S_ENQ_RD: begin
          head_r  <= head_mem[q_idx];
          tail_r  <= tail_mem[q_idx];
          state_r <= S_ENQ_WR;
        end
        S_ENQ_WR: begin
          if (!lvl_set || ath_r) head_mem[q_idx] <= tid_r;
          if (!lvl_set || !ath_r) tail_mem[q_idx] <= tid_r;
          state_r <= S_ENQ_LINK;
        end
        S_ENQ_LINK: begin
          nonempty_r[core_r][lvl_r] <= 1'b1;
          queued_r[tid_r] <= 1'b1;
          count_r[core_r] <= count_r[core_r] + 1'b1;
          state_r <= S_DONE;
        end
        S_SCAN: begin
          if (lvl_set) state_r <= S_HEAD_RD;
          else if (lvl_r == '0) state_r <= S_DONE;
          else lvl_r <= lvl_r - 1'b1;
        end
        S_HEAD_RD: begin
          head_r  <= head_mem[q_idx];
          tail_r  <= tail_mem[q_idx];
          cur_r   <= head_mem[q_idx];
          state_r <= S_SLOT_RD;
        end
        S_SLOT_RD: state_r <= S_SLOT_CHK;
        S_SLOT_CHK: begin
          nxt_r <= nl_rd; prv_r <= pl_rd;
          sfp_r <= at_rd[10:7]; sp_r <= at_rd[6:3]; saff_r <= at_rd[2:0];
          if (op_r == OP_DEQ || cur_free) state_r <= S_UNL_WR;
          else if (!is_tail) begin
            cur_r <= nl_rd; state_r <= S_SLOT_RD;
          end else if (lvl_r == '0) state_r <= S_DONE;
          else begin
            lvl_r <= lvl_r - 1'b1; state_r <= S_SCAN;
          end
        end
        S_UNL_WR: begin
          if (is_head && is_tail) nonempty_r[core_r][lvl_r] <= 1'b0;
          else begin
            if (is_head) head_mem[q_idx] <= nxt_r;
            if (is_tail) tail_mem[q_idx] <= prv_r;
          end
          queued_r[cur_r] <= 1'b0;
          if (count_r[core_r] != '0) count_r[core_r] <= count_r[core_r] - 1'b1;
          state_r <= S_UNL_WR2;
        end
        S_UNL_WR2: begin
          found_r <= 1'b1;
          if (op_r == OP_DEQ && in_band)
            sp_r <= (np[4] || np[3:0] < ts_low_r) ? sfp_r : np[3:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          cnt_out_r <= bad_r ? 7'd0 : 7'(count_r[core_r]);
          state_r <= S_OUT;
        end
        S_OUT: if (out_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result fields read zero when nothing was removed
  assign out_found              = found_r;
  assign out_out_thread         = found_r ? 6'(cur_r) : 6'd0;
  assign out_out_priority       = found_r ? sp_r : 4'd0;
  assign out_out_fixed_priority = found_r ? sfp_r : 4'd0;
  assign out_out_affinity       = found_r ? saff_r : 3'd0;
  assign out_ready_count        = cnt_out_r;

  `PCRQ_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !out_valid)
  `PCRQ_ASSERT_NXT(a_out_done, clk, rst_n, out_fire, in_ready)
  `PCRQ_ASSERT_IMP(a_found_deq, clk, rst_n, out_valid && out_found, op_r != OP_ENQ)
endmodule
